// ===== rtl/core/nearest_four_select_macros.svh =====
// assertion macros for the nearest_four_select checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef NEAREST_FOUR_SELECT_MACROS_SVH
`define NEAREST_FOUR_SELECT_MACROS_SVH

// cond at one edge implies prop at the next edge
`define NFS_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

// sig holds its value into the next edge while cond is true
`define NFS_ASSERT_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== rtl/core/nfs_pkg.sv =====
// shared constants and types for nearest_four_select
// no dependencies
package nfs_pkg;

    localparam int NUM_NEAREST_DEF = 4;
    localparam int COORD_BITS_DEF  = 24;
    localparam int ID_BITS_DEF     = 16;

    localparam int DIST_BITS    = 51;
    localparam int OUT_ID_BITS  = 16;
    localparam int RANK_BITS    = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_X = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_Y = 1'b1;

    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
    } t_cell_ctl;

endpackage

// ===== rtl/core/nfs_dist.sv =====
// three-stage squared distance pipeline: abs difference, square, sum and saturate
// depends on nfs_pkg
module nfs_dist
    import nfs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [ID_BITS-1:0]    i_id,
    input  logic [COORD_BITS-1:0] i_cx,
    input  logic [COORD_BITS-1:0] i_cy,
    input  logic                  i_end,
    input  logic [COORD_BITS-1:0] i_qx,
    input  logic [COORD_BITS-1:0] i_qy,
    output logic                  o_valid,
    output logic [ID_BITS-1:0]    o_id,
    output logic [DIST_BITS-1:0]  o_dist,
    output logic                  o_end
);

    localparam int PROD_W = 2 * COORD_BITS;
    localparam int SUM_W  = PROD_W + 1;

    logic [COORD_BITS:0]   w_dx_full;
    logic [COORD_BITS:0]   w_dy_full;
    logic [COORD_BITS-1:0] n_dx;
    logic [COORD_BITS-1:0] n_dy;
    logic [SUM_W-1:0]      w_sum;
    logic [DIST_BITS-1:0]  n_dist;

    logic                  r_s1_valid, r_s2_valid, r_s3_valid;
    logic                  r_s1_end, r_s2_end, r_s3_end;
    logic [ID_BITS-1:0]    r_s1_id, r_s2_id, r_s3_id;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [PROD_W-1:0]     r_px, r_py;
    logic [DIST_BITS-1:0]  r_dist;

    assign w_dx_full = {i_cx[COORD_BITS-1], i_cx} - {i_qx[COORD_BITS-1], i_qx};
    assign w_dy_full = {i_cy[COORD_BITS-1], i_cy} - {i_qy[COORD_BITS-1], i_qy};

    // magnitude fits in COORD_BITS bits
    assign n_dx = w_dx_full[COORD_BITS] ? (~w_dx_full[COORD_BITS-1:0] + 1'b1)
                                        : w_dx_full[COORD_BITS-1:0];
    assign n_dy = w_dy_full[COORD_BITS] ? (~w_dy_full[COORD_BITS-1:0] + 1'b1)
                                        : w_dy_full[COORD_BITS-1:0];

    assign w_sum = {1'b0, r_px} + {1'b0, r_py};

    generate
        if (SUM_W > DIST_BITS) begin : g_sat
            assign n_dist = (|w_sum[SUM_W-1:DIST_BITS]) ? {DIST_BITS{1'b1}}
                                                         : w_sum[DIST_BITS-1:0];
        end else begin : g_fit
            assign n_dist = DIST_BITS'(w_sum);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_id  <= i_id;
            r_s1_end <= i_end;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_s2_id  <= r_s1_id;
            r_s2_end <= r_s1_end;
            r_px     <= r_dx * r_dx;
            r_py     <= r_dy * r_dy;
            r_s3_id  <= r_s2_id;
            r_s3_end <= r_s2_end;
            r_dist   <= n_dist;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_id    = r_s3_id;
    assign o_dist  = r_dist;
    assign o_end   = r_s3_end;

endmodule

// ===== rtl/core/nfs_cell.sv =====
// one sorted slot of the nearest-neighbor chain; takes the newcomer or its left neighbor
// depends on nfs_pkg
module nfs_cell
    import nfs_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_ins,
    input  logic                 i_clr,
    input  logic [ID_BITS-1:0]   i_new_id,
    input  logic [DIST_BITS-1:0] i_new_dist,
    input  t_cell_ctl            i_left_ctl,
    input  logic [ID_BITS-1:0]   i_left_id,
    input  logic [DIST_BITS-1:0] i_left_dist,
    output t_cell_ctl            o_ctl,
    output logic [ID_BITS-1:0]   o_id,
    output logic [DIST_BITS-1:0] o_dist,
    output logic                 o_nxt_valid,
    output logic [ID_BITS-1:0]   o_nxt_id,
    output logic [DIST_BITS-1:0] o_nxt_dist
);

    logic                 r_valid;
    logic [ID_BITS-1:0]   r_id;
    logic [DIST_BITS-1:0] r_dist;
    logic                 n_valid;
    logic [ID_BITS-1:0]   n_id;
    logic [DIST_BITS-1:0] n_dist;

    assign o_ctl.valid = r_valid;
    assign o_ctl.lt    = r_valid && (r_dist < i_new_dist);
    assign o_ctl.eq    = r_valid && (r_dist == i_new_dist);

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_dist  = r_dist;
        if (i_ins && !o_ctl.lt) begin
            if (i_left_ctl.lt) begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_dist  = i_new_dist;
            end else begin
                n_valid = i_left_ctl.valid;
                n_id    = i_left_id;
                n_dist  = i_left_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid && !i_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_id   <= n_id;
            r_dist <= n_dist;
        end
    end

    assign o_id        = r_id;
    assign o_dist      = r_dist;
    assign o_nxt_valid = n_valid;
    assign o_nxt_id    = n_id;
    assign o_nxt_dist  = n_dist;

endmodule

// ===== rtl/core/nfs_drain.sv =====
// result buffer: captures chain at set end; while i_ready, shifts one out per cycle
// depends on nfs_pkg
module nfs_drain
    import nfs_pkg::*;
#(
    parameter int NUM_NEAREST = NUM_NEAREST_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [NUM_NEAREST-1:0] i_ld_valid,
    input  logic [ID_BITS-1:0]     i_ld_id   [NUM_NEAREST],
    input  logic [DIST_BITS-1:0]   i_ld_dist [NUM_NEAREST],
    input  logic                   i_ready,
    output logic                   o_free,
    output logic                   o_valid,
    output logic [OUT_ID_BITS-1:0] o_neighbor_id,
    output logic [DIST_BITS-1:0]   o_sq_distance,
    output logic [RANK_BITS-1:0]   o_rank,
    output logic                   o_run_end
);

    localparam int CNT_W = $clog2(NUM_NEAREST + 1);

    logic [CNT_W-1:0]     r_cnt;
    logic [RANK_BITS-1:0] r_rank;
    logic [ID_BITS-1:0]   r_buf_id   [NUM_NEAREST];
    logic [DIST_BITS-1:0] r_buf_dist [NUM_NEAREST];
    logic                 w_take;

    assign o_valid   = (r_cnt != '0);
    assign w_take    = o_valid && i_ready;
    assign o_run_end = (r_cnt == CNT_W'(1));
    assign o_free    = !o_valid || (o_run_end && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rank <= '0;
        end else if (i_load) begin
            r_cnt  <= CNT_W'($countones(i_ld_valid));
            r_rank <= '0;
        end else if (w_take) begin
            r_cnt  <= r_cnt - 1'b1;
            r_rank <= r_rank + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < NUM_NEAREST; k++) begin
                r_buf_id[k]   <= i_ld_id[k];
                r_buf_dist[k] <= i_ld_dist[k];
            end
        end else if (w_take) begin
            for (int k = 0; k < NUM_NEAREST - 1; k++) begin
                r_buf_id[k]   <= r_buf_id[k+1];
                r_buf_dist[k] <= r_buf_dist[k+1];
            end
        end
    end

    assign o_neighbor_id = OUT_ID_BITS'(r_buf_id[0]);
    assign o_sq_distance = r_buf_dist[0];
    assign o_rank        = r_rank;

endmodule

// ===== rtl/core/nearest_four_select.sv =====
// nearest_four_select top level: distance pipeline, chain of slot cells, result buffer
// depends on nfs_pkg, nfs_dist, nfs_cell, nfs_drain
//
// Accepts one cell per clock. Each cell's squared distance to the query point
// is formed in a three-stage pipeline, and once it leaves the third stage the
// cell is inserted into a chain of NUM_NEAREST slot cells that keep it in
// ascending order (a tie with a kept distance drops the newcomer). When the
// request marked set end reaches the chain, the kept slots move to the result
// buffer and the chain clears in the same cycle; results then leave one per
// cycle while i_ready is high, rank 0 first, run end on the last. Input is held
// off only while a set-end request waits at the chain for the previous run's
// results to be taken.
module nearest_four_select
    import nfs_pkg::*;
#(
    parameter int NUM_NEAREST = NUM_NEAREST_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [COORD_BITS-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ID_BITS-1:0]           i_cell_id,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic                         i_set_end,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [OUT_ID_BITS-1:0]       o_neighbor_id,
    output logic [DIST_BITS-1:0]         o_sq_distance,
    output logic [RANK_BITS-1:0]         o_rank,
    output logic                         o_run_end
);

    logic [COORD_BITS-1:0] r_qx;
    logic [COORD_BITS-1:0] r_qy;

    logic                  w_en;
    logic                  w_drain_free;
    logic                  w_s3_valid;
    logic [ID_BITS-1:0]    w_s3_id;
    logic [DIST_BITS-1:0]  w_s3_dist;
    logic                  w_s3_end;
    logic                  w_ins;
    logic                  w_clr;
    logic [NUM_NEAREST-1:0] w_eq;

    t_cell_ctl              w_ctl      [NUM_NEAREST+1];
    logic [ID_BITS-1:0]     w_id       [NUM_NEAREST+1];
    logic [DIST_BITS-1:0]   w_dist     [NUM_NEAREST+1];
    logic [NUM_NEAREST-1:0] w_nxt_valid;
    logic [ID_BITS-1:0]     w_nxt_id   [NUM_NEAREST];
    logic [DIST_BITS-1:0]   w_nxt_dist [NUM_NEAREST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUERY_X: r_qx <= i_cfg_data;
                CFG_QUERY_Y: r_qy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a set-end request may not reach the chain until the buffer is free
    assign w_en    = !(w_s3_valid && w_s3_end && !w_drain_free);
    assign o_ready = w_en;

    nfs_dist #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_id    (i_cell_id),
        .i_cx    (i_center_x),
        .i_cy    (i_center_y),
        .i_end   (i_set_end),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_valid (w_s3_valid),
        .o_id    (w_s3_id),
        .o_dist  (w_s3_dist),
        .o_end   (w_s3_end)
    );

    assign w_ins = w_s3_valid && !(|w_eq);
    assign w_clr = w_s3_valid && w_s3_end;

    // head of the chain: the newcomer always lands at or after slot 0
    assign w_ctl[0]  = '{valid: 1'b0, lt: 1'b1, eq: 1'b0};
    assign w_id[0]   = '0;
    assign w_dist[0] = '0;

    generate
        for (genvar g = 0; g < NUM_NEAREST; g++) begin : g_cell
            nfs_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (w_en),
                .i_ins       (w_ins),
                .i_clr       (w_clr),
                .i_new_id    (w_s3_id),
                .i_new_dist  (w_s3_dist),
                .i_left_ctl  (w_ctl[g]),
                .i_left_id   (w_id[g]),
                .i_left_dist (w_dist[g]),
                .o_ctl       (w_ctl[g+1]),
                .o_id        (w_id[g+1]),
                .o_dist      (w_dist[g+1]),
                .o_nxt_valid (w_nxt_valid[g]),
                .o_nxt_id    (w_nxt_id[g]),
                .o_nxt_dist  (w_nxt_dist[g])
            );
            assign w_eq[g] = w_ctl[g+1].eq;
        end
    endgenerate

    nfs_drain #(
        .NUM_NEAREST (NUM_NEAREST),
        .ID_BITS     (ID_BITS)
    ) u_drain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_en && w_clr),
        .i_ld_valid    (w_nxt_valid),
        .i_ld_id       (w_nxt_id),
        .i_ld_dist     (w_nxt_dist),
        .i_ready       (i_ready),
        .o_free        (w_drain_free),
        .o_valid       (o_valid),
        .o_neighbor_id (o_neighbor_id),
        .o_sq_distance (o_sq_distance),
        .o_rank        (o_rank),
        .o_run_end     (o_run_end)
    );

endmodule

// ===== rtl/core/nfs_checker.sv =====
// port-level checks on the nearest_four_select result channel, bound to the top level
// depends on nfs_pkg and nearest_four_select_macros.svh
`include "nearest_four_select_macros.svh"

module nfs_checker
    import nfs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [OUT_ID_BITS-1:0] o_neighbor_id,
    input logic [DIST_BITS-1:0]   o_sq_distance,
    input logic [RANK_BITS-1:0]   o_rank,
    input logic                   o_run_end
);

    `NFS_ASSERT_HOLD(a_dist_hold, o_valid && !i_ready, o_sq_distance, "stalled result changed")

    `NFS_ASSERT_HOLD(a_id_hold, o_valid && !i_ready, o_neighbor_id, "stalled result id changed")

    `NFS_ASSERT_NEXT(a_rank_step, o_valid && i_ready && !o_run_end, o_valid && (o_rank == $past(o_rank) + 1'b1), "rank did not advance within a run")

    `NFS_ASSERT_NEXT(a_rank_restart, o_valid && i_ready && o_run_end, !o_valid || (o_rank == '0), "new run does not start at rank zero")

    `NFS_ASSERT_NEXT(a_dist_order, o_valid && i_ready && !o_run_end, o_sq_distance > $past(o_sq_distance), "distances not strictly ascending")

endmodule

bind nearest_four_select nfs_checker u_nfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_neighbor_id (o_neighbor_id),
    .o_sq_distance (o_sq_distance),
    .o_rank        (o_rank),
    .o_run_end     (o_run_end)
);
